// ===== design/priority_ready_queue_scheduler_defines.svh =====
// assertion macros for the ready queue scheduler checker
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define PRQS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define PRQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/prqs_pkg.sv =====
// types and constants of the ready queue scheduler
`default_nettype none
package prqs_pkg;
    localparam logic [1:0] FUNC_INSERT   = 2'd0;
    localparam logic [1:0] FUNC_REMOVE   = 2'd1;
    localparam logic [1:0] FUNC_SCHEDULE = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [4:0] thread_id;
        logic [4:0] priority_req;
    } t_in;

    typedef struct packed {
        logic [4:0] selected_thread;
        logic [4:0] selected_priority;
        logic       switch_needed;
        logic [4:0] previous_thread;
        logic       previous_valid;
        logic       none_ready;
        logic       op_error;
    } t_out;
endpackage
`default_nettype wire

// ===== design/prqs_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module prqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/priority_ready_queue_scheduler.sv =====
// ready queue scheduler: priority bitmap with linked fifos in ram
// steps: idle accepts, read looks up the rams, link updates the queues, remove adds a done step,
// then out presents the result; one transaction at a time, as o_stall stays high until the
// result has left through the output handshake
// reset clears bitmap, ready flags and running state at once; rams need no clearing
`default_nettype none
module priority_ready_queue_scheduler #(
    parameter int PRIORITY_LEVELS = 32,
    parameter int THREAD_COUNT    = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire prqs_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output prqs_pkg::t_out      o_data
);
    localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int TW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_LINK = 3'd2,
                           S_DONE = 3'd3, S_OUT = 3'd4;

    logic [2:0] r_state;
    prqs_pkg::t_in r_in;
    logic [PRIORITY_LEVELS-1:0] r_bitmap;
    logic [THREAD_COUNT-1:0] r_ready;
    logic [PW-1:0] r_tprio [THREAD_COUNT];
    logic [TW-1:0] r_run_t;
    logic r_run_v;
    logic [PW-1:0] r_run_p;
    logic [PW-1:0] r_hp;
    logic r_err, r_none;
    logic [TW-1:0] r_head, r_tail, r_nx, r_pv;

    logic [TW-1:0] w_t;
    logic [PW-1:0] w_p;
    logic w_range;
    assign w_t = TW'(r_in.thread_id);
    assign w_p = PW'(r_in.priority_req);
    assign w_range = (32'(r_in.thread_id) < THREAD_COUNT)
                   && (32'(r_in.priority_req) < PRIORITY_LEVELS);

    // head/tail rams (addressed by priority), link rams (by thread)
    logic hd_we, tl_we, nx_we, pv_we;
    logic [PW-1:0] hd_wa, tl_wa, q_ra;
    logic [TW-1:0] hd_wd, tl_wd, nx_wa, nx_wd, pv_wa, pv_wd, l_ra;
    logic [TW-1:0] hd_rd, tl_rd, nx_rd, pv_rd;

    prqs_ram #(.WIDTH(TW), .DEPTH(PRIORITY_LEVELS)) u_head (.i_clk, .i_we(hd_we),
        .i_waddr(hd_wa), .i_wdata(hd_wd), .i_raddr(q_ra), .o_rdata(hd_rd));
    prqs_ram #(.WIDTH(TW), .DEPTH(PRIORITY_LEVELS)) u_tail (.i_clk, .i_we(tl_we),
        .i_waddr(tl_wa), .i_wdata(tl_wd), .i_raddr(q_ra), .o_rdata(tl_rd));
    prqs_ram #(.WIDTH(TW), .DEPTH(THREAD_COUNT)) u_next (.i_clk, .i_we(nx_we),
        .i_waddr(nx_wa), .i_wdata(nx_wd), .i_raddr(l_ra), .o_rdata(nx_rd));
    prqs_ram #(.WIDTH(TW), .DEPTH(THREAD_COUNT)) u_prev (.i_clk, .i_we(pv_we),
        .i_waddr(pv_wa), .i_wdata(pv_wd), .i_raddr(l_ra), .o_rdata(pv_rd));

    // lowest set bit of the bitmap
    logic [PW-1:0] w_lsb;
    always_comb begin
        w_lsb = '0;
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
            if (r_bitmap[i]) w_lsb = PW'(i);
        end
    end

    logic w_bad;
    always_comb begin
        w_bad = 1'b1;
        case (r_in.func)
            prqs_pkg::FUNC_INSERT: w_bad = !w_range || r_ready[w_t];
            prqs_pkg::FUNC_REMOVE: w_bad = !w_range || !r_ready[w_t] || r_tprio[w_t] != w_p;
            prqs_pkg::FUNC_SCHEDULE: w_bad = 1'b0;
            default: w_bad = 1'b1;
        endcase
    end

    assign q_ra = (r_in.func == prqs_pkg::FUNC_SCHEDULE) ? w_lsb : w_p;
    assign l_ra = w_t;

    logic w_hd, w_tl;
    assign w_hd = (hd_rd == w_t);
    assign w_tl = (tl_rd == w_t);

    logic w_switch;
    prqs_pkg::t_out n_data;
    assign w_switch = !r_none && (!r_run_v || hd_rd != r_run_t);

    always_comb begin
        n_data = '0;
        n_data.op_error = r_err;
        if (r_in.func == prqs_pkg::FUNC_SCHEDULE) begin
            n_data.none_ready = r_none;
            if (w_switch) begin
                n_data.switch_needed = 1'b1;
                n_data.previous_valid = r_run_v;
                n_data.previous_thread = r_run_v ? 5'(r_run_t) : 5'd0;
            end
        end
    end

    always_comb begin
        hd_we = 1'b0; tl_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
        hd_wa = w_p; tl_wa = w_p; hd_wd = w_t; tl_wd = w_t;
        nx_wa = tl_rd; nx_wd = w_t; pv_wa = w_t; pv_wd = tl_rd;
        if (r_state == S_LINK && !r_err) begin
            if (r_in.func == prqs_pkg::FUNC_INSERT) begin
                tl_we = 1'b1;
                if (r_bitmap[w_p]) begin
                    nx_we = 1'b1;
                    pv_we = 1'b1;
                end else begin
                    hd_we = 1'b1;
                end
            end
        end
        if (r_state == S_DONE && !r_err && r_in.func == prqs_pkg::FUNC_REMOVE) begin
            if (r_head == w_t && r_tail == w_t) begin
            end else if (r_head == w_t) begin
                hd_we = 1'b1; hd_wd = r_nx;
            end else if (r_tail == w_t) begin
                tl_we = 1'b1; tl_wd = r_pv;
            end else begin
                nx_we = 1'b1; nx_wa = r_pv; nx_wd = r_nx;
                pv_we = 1'b1; pv_wa = r_nx; pv_wd = r_pv;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bitmap <= '0;
            r_ready <= '0;
            r_run_t <= '0;
            r_run_v <= 1'b0;
            r_run_p <= PW'(PRIORITY_LEVELS - 1);
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_in <= i_data;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_err <= w_bad;
                    r_none <= (r_bitmap == '0);
                    r_hp <= w_lsb;
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    r_head <= hd_rd;
                    r_tail <= tl_rd;
                    r_nx <= nx_rd;
                    r_pv <= pv_rd;
                    o_data <= n_data;
                    r_state <= S_OUT;
                    if (!r_err && r_in.func == prqs_pkg::FUNC_INSERT) begin
                        r_bitmap[w_p] <= 1'b1;
                        r_ready[w_t] <= 1'b1;
                        r_tprio[w_t] <= w_p;
                    end else if (!r_err && r_in.func == prqs_pkg::FUNC_REMOVE) begin
                        r_ready[w_t] <= 1'b0;
                        if (w_hd && w_tl) r_bitmap[w_p] <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_in.func == prqs_pkg::FUNC_SCHEDULE) begin
                        if (w_switch) begin
                            r_run_t <= hd_rd;
                            r_run_v <= 1'b1;
                            r_run_p <= r_hp;
                        end
                    end
                end
                S_DONE: r_state <= S_OUT;
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        o_data.selected_thread <= r_run_v ? 5'(r_run_t) : 5'd0;
                        o_data.selected_priority <= 5'(r_run_p);
                    end else if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/prqs_checker.sv =====
// port level checker for the ready queue scheduler
`default_nettype none
`include "priority_ready_queue_scheduler_defines.svh"
module prqs_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_valid,
    input wire logic           o_stall,
    input wire logic           o_valid,
    input wire logic           i_stall,
    input wire prqs_pkg::t_out o_data
);
    `PRQS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `PRQS_ASSERT_IMPL(a_busy_out, i_clk, i_rst_n, o_valid, o_stall)
    `PRQS_ASSERT_IMPL(a_sw_prev, i_clk, i_rst_n, o_valid && o_data.previous_valid,
        o_data.switch_needed)
    `PRQS_ASSERT_IMPL(a_excl, i_clk, i_rst_n, o_valid && o_data.none_ready,
        !o_data.switch_needed && !o_data.op_error)
endmodule
bind priority_ready_queue_scheduler prqs_checker u_prqs_checker (.*);
`default_nettype wire

// ===== verif/tb.sv =====
// testbench for the priority ready queue scheduler
`default_nettype none
module tb;
    localparam int LEVELS  = 32;
    localparam int THREADS = 32;
    localparam int LONG_HOLD = 200;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    prqs_pkg::t_in  i_data;
    logic o_valid;
    logic i_stall;
    prqs_pkg::t_out o_data;

    priority_ready_queue_scheduler #(
        .PRIORITY_LEVELS(LEVELS),
        .THREAD_COUNT(THREADS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data(o_data)
    );

    // scheduler shadow state
    logic [31:0] sh_bitmap;
    logic [4:0]  sh_head [LEVELS];
    logic [4:0]  sh_tail [LEVELS];
    logic [4:0]  sh_next [THREADS];
    logic [4:0]  sh_prev [THREADS];
    logic        sh_ready [THREADS];
    logic [4:0]  sh_prio [THREADS];
    logic [4:0]  sh_run_thread;
    logic        sh_run_valid;
    logic [4:0]  sh_run_prio;

    prqs_pkg::t_out sched_results_due[$];
    int   errors = 0;
    int   hold_cycles = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    bit   long_gaps;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #80000000;
        $display("status: fail");
        $finish;
    end

    function automatic prqs_pkg::t_out sched_predict(prqs_pkg::t_in tr);
        prqs_pkg::t_out r;
        logic [4:0] t;
        logic [4:0] p;
        logic [4:0] nx;
        logic [4:0] pv;
        logic [4:0] pick;
        int hp;
        r = '0;
        t = tr.thread_id;
        p = tr.priority_req;
        if (tr.func == prqs_pkg::FUNC_INSERT) begin
            if (sh_ready[t]) begin
                r.op_error = 1'b1;
            end else begin
                if (sh_bitmap[p]) begin
                    sh_next[sh_tail[p]] = t;
                    sh_prev[t] = sh_tail[p];
                    sh_tail[p] = t;
                end else begin
                    sh_head[p] = t;
                    sh_tail[p] = t;
                    sh_bitmap[p] = 1'b1;
                end
                sh_ready[t] = 1'b1;
                sh_prio[t] = p;
            end
        end else if (tr.func == prqs_pkg::FUNC_REMOVE) begin
            if (!sh_ready[t] || sh_prio[t] != p) begin
                r.op_error = 1'b1;
            end else begin
                nx = sh_next[t];
                pv = sh_prev[t];
                if (sh_head[p] == t && sh_tail[p] == t) begin
                    sh_bitmap[p] = 1'b0;
                end else if (sh_head[p] == t) begin
                    sh_head[p] = nx;
                end else if (sh_tail[p] == t) begin
                    sh_tail[p] = pv;
                end else begin
                    sh_next[pv] = nx;
                    sh_prev[nx] = pv;
                end
                sh_ready[t] = 1'b0;
            end
        end else if (tr.func == prqs_pkg::FUNC_SCHEDULE) begin
            if (sh_bitmap == '0) begin
                r.none_ready = 1'b1;
            end else begin
                hp = 0;
                while (!sh_bitmap[hp]) hp++;
                pick = sh_head[hp];
                if (!sh_run_valid || pick != sh_run_thread) begin
                    r.switch_needed = 1'b1;
                    if (sh_run_valid) begin
                        r.previous_valid = 1'b1;
                        r.previous_thread = sh_run_thread;
                    end
                    sh_run_thread = pick;
                    sh_run_valid = 1'b1;
                    sh_run_prio = 5'(hp);
                end
            end
        end else begin
            r.op_error = 1'b1;
        end
        r.selected_thread = sh_run_valid ? sh_run_thread : 5'd0;
        r.selected_priority = sh_run_prio;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if (long_gaps && $urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    task automatic send_op(logic [1:0] f, logic [4:0] t, logic [4:0] p);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_data <= '{func: f, thread_id: t, priority_req: p};
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sched_results_due.push_back(sched_predict(i_data));
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        int n;
        n = 0;
        i_valid <= 1'b0;
        while (sched_results_due.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cycles <= LONG_HOLD;
            i_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (long_gaps && $urandom_range(0, 39) == 0) begin
            hold_cycles <= $urandom_range(5, 30);
            i_stall <= 1'b1;
        end else begin
            i_stall <= long_gaps && ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        prqs_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sched_results_due.size() == 0) begin
                $display("%0t unexpected result got %h", $time, o_data);
                errors++;
            end else begin
                want = sched_results_due.pop_front();
                if (o_data !== want) begin
                    $display("%0t mismatch expected %h actual %h", $time, want, o_data);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_op(prqs_pkg::FUNC_SCHEDULE, 5'd0, 5'd0);
        send_op(prqs_pkg::FUNC_REMOVE, 5'd3, 5'd0);
        send_op(prqs_pkg::FUNC_INSERT, 5'd31, 5'd31);
        send_op(prqs_pkg::FUNC_INSERT, 5'd31, 5'd31);
        send_op(prqs_pkg::FUNC_SCHEDULE, 5'd0, 5'd0);
        send_op(prqs_pkg::FUNC_INSERT, 5'd0, 5'd0);
        send_op(prqs_pkg::FUNC_INSERT, 5'd5, 5'd0);
        send_op(prqs_pkg::FUNC_INSERT, 5'd9, 5'd0);
        send_op(prqs_pkg::FUNC_SCHEDULE, 5'd31, 5'd31);
        send_op(prqs_pkg::FUNC_REMOVE, 5'd5, 5'd7);
        send_op(prqs_pkg::FUNC_REMOVE, 5'd5, 5'd0);
        send_op(prqs_pkg::FUNC_REMOVE, 5'd0, 5'd0);
        send_op(prqs_pkg::FUNC_SCHEDULE, 5'd0, 5'd0);
        send_op(prqs_pkg::FUNC_REMOVE, 5'd9, 5'd0);
        send_op(prqs_pkg::FUNC_SCHEDULE, 5'd0, 5'd0);
        send_op(FUNC_UNUSED, 5'd31, 5'd31);
        send_op(prqs_pkg::FUNC_REMOVE, 5'd31, 5'd31);
        send_op(prqs_pkg::FUNC_SCHEDULE, 5'd0, 5'd0);
        send_op(prqs_pkg::FUNC_INSERT, 5'd21, 5'd10);
        send_op(prqs_pkg::FUNC_SCHEDULE, 5'd0, 5'd0);
        wait_drain();
    endtask

    task automatic test_random(int count);
        int r;
        logic [4:0] t;
        logic [4:0] p;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            t = 5'($urandom);
            if (r < 40) begin
                p = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
                send_op(prqs_pkg::FUNC_INSERT, t, p);
            end else if (r < 70) begin
                p = ($urandom_range(0, 4) == 0) ? 5'($urandom) : sh_prio[t];
                send_op(prqs_pkg::FUNC_REMOVE, t, p);
            end else if (r < 97) begin
                send_op(prqs_pkg::FUNC_SCHEDULE, 5'($urandom), 5'($urandom));
            end else begin
                send_op(FUNC_UNUSED, 5'($urandom), 5'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        hold_req++;
        test_random(20);
        wait_drain();
    endtask

    initial begin
        long_gaps = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_rst_n = 1'b0;
        sh_bitmap = '0;
        sh_run_thread = '0;
        sh_run_valid = 1'b0;
        sh_run_prio = 5'(LEVELS - 1);
        for (int i = 0; i < THREADS; i++) begin
            sh_ready[i] = 1'b0;
            sh_prio[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(300);
        long_gaps = 1'b1;
        test_random(700);
        test_backpressure();
        test_random(750);
        wait_drain();
        if (errors == 0 && sched_results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/prqs_pkg.sv
design/prqs_ram.sv
design/priority_ready_queue_scheduler.sv
design/prqs_checker.sv
verif/tb.sv
